// ===== hdl/ssbc_pkg.sv =====
package ssbc_pkg;

  localparam int FracBits = 16;
  localparam int FracW    = FracBits + 2;   // signed fraction, -one .. one
  localparam int TrFW     = FracBits + 1;   // unsigned trace fraction
  localparam int DistW    = 52;             // plane distance in 2^-22 units
  localparam int CntW     = $clog2(FracBits + 8);

  localparam logic signed [FracW-1:0] FracOne  = FracW'(1 << FracBits);
  localparam logic [TrFW-1:0]         TrOne    = TrFW'(1 << FracBits);
  localparam logic signed [DistW-1:0] Margin   = DistW'(1 << 19);
  localparam logic [19:0]             RadiusReset = 20'd7680;

  localparam logic [1:0] KindFurther = 2'd0;
  localparam logic [1:0] KindBrush   = 2'd1;
  localparam logic [1:0] KindTrace   = 2'd2;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [31:0] off;
  } plane_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               last_side;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
  } side_req_t;

  typedef struct packed {
    logic [16:0]        hit_fraction;
    logic               starts_inside;
    logic               all_solid;
    logic signed [15:0] hit_normal_x;
    logic signed [15:0] hit_normal_y;
    logic signed [15:0] hit_normal_z;
    logic signed [31:0] hit_plane_offset;
  } trace_rsp_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       classify;
    logic       div_step;
    logic       update;
    logic       fold;
  } dp_cmd_t;

  typedef struct packed {
    logic rejected;
    logic skip;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/ssbc_dp.sv =====
module ssbc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i,
  input  ssbc_pkg::side_req_t req_i,
  input  ssbc_pkg::dp_cmd_t  cmd_i,
  output ssbc_pkg::dp_status_t status_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output ssbc_pkg::trace_rsp_t out_data_o
);
  import ssbc_pkg::*;

  logic [19:0]             radius_q;
  side_req_t               item_q;
  logic signed [47:0]      prod_q;
  logic                    prod_vld_q, prod_end_q;
  logic signed [DistW-1:0] ds_q, de_q;

  logic signed [FracW-1:0] enter_q, exit_q;
  logic                    bso_q, beo_q, brej_q;
  plane_t                  cand_q;
  logic [TrFW-1:0]         tfrac_q;
  logic                    tso_q, tsolid_q;
  plane_t                  tplane_q;

  logic                    dir_enter_q, zero_q, neg_q, sat_q;
  logic [DistW:0]          rem_q;
  logic [DistW-1:0]        den_q;
  logic [FracBits-1:0]     quo_q;

  logic                    out_vld_q;
  trace_rsp_t              out_q;

  // multiplier operand select
  logic signed [15:0] mul_n;
  logic signed [31:0] mul_c;
  always_comb begin
    unique case (cmd_i.mul_sel)
      3'd0:    begin mul_n = item_q.normal_x; mul_c = item_q.start_x; end
      3'd1:    begin mul_n = item_q.normal_y; mul_c = item_q.start_y; end
      3'd2:    begin mul_n = item_q.normal_z; mul_c = item_q.start_z; end
      3'd3:    begin mul_n = item_q.normal_x; mul_c = item_q.end_x;   end
      3'd4:    begin mul_n = item_q.normal_y; mul_c = item_q.end_y;   end
      default: begin mul_n = item_q.normal_z; mul_c = item_q.end_z;   end
    endcase
  end

  logic signed [33:0]      push_base;
  logic signed [DistW-1:0] push;
  assign push_base = 34'(signed'(req_i.plane_offset)) + $signed({14'b0, radius_q});
  assign push = DistW'(push_base) <<< 14;

  // side classification
  logic                    ds_pos, de_pos, enter_dir;
  logic signed [DistW-1:0] diff, n_enter, n_leave, mag;
  assign ds_pos    = ds_q > 0;
  assign de_pos    = de_q > 0;
  assign enter_dir = ds_q > de_q;
  assign diff      = enter_dir ? ds_q - de_q : de_q - ds_q;
  assign n_enter   = ds_q - Margin;
  assign n_leave   = -(ds_q + Margin);
  always_comb begin
    if (enter_dir) mag = n_enter;
    else if (n_leave < 0) mag = -n_leave;
    else mag = n_leave;
  end

  // restoring divider step
  logic [DistW:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q[DistW-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  // side fraction
  logic signed [FracW-1:0] quo_s, f;
  assign quo_s = $signed({2'b00, quo_q});
  always_comb begin
    if (dir_enter_q) begin
      if (zero_q) f = '0;
      else if (sat_q) f = FracOne;
      else f = quo_s;
    end else if (sat_q) begin
      f = neg_q ? -FracOne : FracOne;
    end else begin
      f = neg_q ? -quo_s : quo_s;
    end
  end

  logic signed [FracW-1:0] tfrac_s;
  logic                    take_enter;
  assign tfrac_s    = $signed({1'b0, tfrac_q});
  assign take_enter = (enter_q < exit_q) && (enter_q > -FracOne) && (enter_q < tfrac_s);

  // trace state once the current brush is folded in
  logic [TrFW-1:0]  fold_frac;
  logic             fold_so, fold_solid;
  plane_t           fold_plane;
  logic [TrFW+16:0] fold_ext;
  always_comb begin
    fold_frac  = tfrac_q;
    fold_so    = tso_q;
    fold_solid = tsolid_q;
    fold_plane = tplane_q;
    if (!brej_q) begin
      if (!bso_q) begin
        fold_so = 1'b0;
        if (!beo_q) begin
          fold_solid = 1'b1;
          fold_frac  = '0;
        end
      end else if (take_enter) begin
        fold_frac  = TrFW'(enter_q);
        fold_plane = cand_q;
      end
    end
  end
  assign fold_ext = {17'b0, fold_frac};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= RadiusReset;
      prod_vld_q <= 1'b0;
      enter_q    <= -FracOne;
      exit_q     <= FracOne;
      bso_q      <= 1'b0;
      beo_q      <= 1'b0;
      brej_q     <= 1'b0;
      cand_q     <= '0;
      tfrac_q    <= TrOne;
      tso_q      <= 1'b1;
      tsolid_q   <= 1'b0;
      tplane_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      prod_vld_q <= cmd_i.mul_en;
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;

      if (cmd_i.load) begin
        if (req_i.kind == KindTrace) begin
          tfrac_q  <= TrOne;
          tso_q    <= 1'b1;
          tsolid_q <= 1'b0;
        end
        if (req_i.kind == KindBrush || req_i.kind == KindTrace) begin
          enter_q <= -FracOne;
          exit_q  <= FracOne;
          bso_q   <= 1'b0;
          beo_q   <= 1'b0;
          brej_q  <= 1'b0;
          cand_q  <= '0;
        end
      end

      if (cmd_i.classify) begin
        if (ds_pos) bso_q <= 1'b1;
        if (de_pos) beo_q <= 1'b1;
        if (ds_pos && de_pos) brej_q <= 1'b1;
      end

      if (cmd_i.update) begin
        if (dir_enter_q) begin
          if (f > enter_q) begin
            enter_q <= f;
            cand_q  <= '{nx: item_q.normal_x, ny: item_q.normal_y,
                         nz: item_q.normal_z, off: item_q.plane_offset};
          end
        end else if (f < exit_q) begin
          exit_q <= f;
        end
      end

      if (cmd_i.fold) begin
        out_vld_q <= 1'b1;
        tfrac_q   <= fold_frac;
        tso_q     <= fold_so;
        tsolid_q  <= fold_solid;
        tplane_q  <= fold_plane;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i;
      ds_q   <= -push;
      de_q   <= -push;
    end else if (prod_vld_q) begin
      if (prod_end_q) de_q <= de_q + DistW'(prod_q);
      else ds_q <= ds_q + DistW'(prod_q);
    end
    if (cmd_i.mul_en) begin
      prod_q     <= mul_n * mul_c;
      prod_end_q <= cmd_i.mul_sel >= 3'd3;
    end
    if (cmd_i.classify) begin
      dir_enter_q <= enter_dir;
      zero_q      <= n_enter <= 0;
      neg_q       <= n_leave < 0;
      sat_q       <= mag >= diff;
      den_q       <= DistW'(diff);
      rem_q       <= {1'b0, mag};
      quo_q       <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[FracBits-2:0], rem_ge};
    end
    // hold the folded result while the trace state moves on
    if (cmd_i.fold) begin
      out_q.hit_fraction     <= fold_ext[16:0];
      out_q.starts_inside    <= !fold_so;
      out_q.all_solid        <= fold_solid;
      out_q.hit_normal_x     <= fold_plane.nx;
      out_q.hit_normal_y     <= fold_plane.ny;
      out_q.hit_normal_z     <= fold_plane.nz;
      out_q.hit_plane_offset <= fold_plane.off;
    end
  end

  assign out_data_o        = out_q;
  assign out_valid_o       = out_vld_q;
  assign status_o.rejected = brej_q;
  assign status_o.skip     = (ds_pos && de_pos) || (!ds_pos && !de_pos);
  assign status_o.last     = item_q.last_side;
  assign status_o.out_free = !out_vld_q;

endmodule

// ===== hdl/ssbc_ctrl.sv =====
module ssbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ssbc_pkg::dp_status_t status_i,
  output ssbc_pkg::dp_cmd_t    cmd_o
);
  import ssbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CLS  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_FOLD = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      done_state;

  assign done_state = status_i.last ? S_FOLD : S_IDLE;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_CHK;
      end
      S_CHK: begin
        cnt_d   = '0;
        state_d = status_i.rejected ? done_state : S_MUL;
      end
      S_MUL: begin
        // six products; the last one accumulates from the product register before classification
        cmd_o.mul_en  = cnt_q < CntW'(6);
        cmd_o.mul_sel = cnt_q[2:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(6)) state_d = S_CLS;
      end
      S_CLS: begin
        cmd_o.classify = 1'b1;
        cnt_d   = '0;
        state_d = status_i.skip ? done_state : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(FracBits - 1)) state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d = done_state;
      end
      S_FOLD: begin
        // hold until the previous result has been taken
        cmd_o.fold = status_i.out_free;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hdl/swept_sphere_brush_clip_top.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   in_data_i  (side_req_t)
// out       output     out_valid_o / out_stall_i out_data_o (trace_rsp_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (sphere radius)
//
// A side passes through load and check, six products on the shared 16x32
// multiplier, classification, then 16 divider steps and an update when the
// segment crosses the plane, plus a fold on a last side.
// The radix-2 divider accounts for most of a side's processing.
// Reset (rst_ni low, asynchronous) restores all brush and trace state and the
// radius; the fold waits while a previous result is stalled on the out side.
module swept_sphere_brush_clip_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [19:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ssbc_pkg::side_req_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ssbc_pkg::trace_rsp_t  out_data_o
);
  import ssbc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ssbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_solid_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.all_solid || out_data_o.starts_inside))
    else $error("all_solid without starts_inside");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while busy");

  a_fold_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fold |-> !out_valid_o)
    else $error("fold over an undelivered result");
`endif

endmodule
